// File: rtl/ip_lease_pool_unit_defines.svh
// assertion macros shared by the lease pool checker
`ifndef IP_LEASE_POOL_UNIT_DEFINES_SVH
`define IP_LEASE_POOL_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define LPU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lease pool check failed");

// next-cycle implication, disabled while reset is low
`define LPU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lease pool check failed");

`endif

// File: rtl/lpu_pkg.sv
// types, codes and sizes of the address lease pool
`timescale 1ns / 1ps
package lpu_pkg;

	localparam int POOL_ENTRIES = 64;
	localparam int IDX_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
	localparam int FREED_W = 7;
	localparam logic [FREED_W-1:0] FREED_MAX = '1;

	localparam logic [1:0] ACT_SWEEP = 2'd0;
	localparam logic [1:0] ACT_DISCOVER = 2'd1;
	localparam logic [1:0] ACT_REQUEST = 2'd2;

	localparam logic [1:0] RES_OK = 2'd0;
	localparam logic [1:0] RES_NO_FREE = 2'd1;
	localparam logic [1:0] RES_BAD_ADDR = 2'd2;
	localparam logic [1:0] RES_SWEEP = 2'd3;

	localparam logic [1:0] REG_BASE = 2'd0;
	localparam logic [1:0] REG_OFFER = 2'd1;
	localparam logic [1:0] REG_LEASE = 2'd2;

	localparam logic [31:0] BASE_RESET = 32'd3232235620;
	localparam logic [31:0] OFFER_RESET = 32'd10;
	localparam logic [31:0] LEASE_RESET = 32'd3600;

	typedef enum logic [1:0] {
		ENT_FREE = 2'd0,
		ENT_OFFERED = 2'd1,
		ENT_BOUND = 2'd2
	} ent_state_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HOLD
	} state_t;

	typedef struct packed {
		ent_state_t  state;
		logic [47:0] mac;
		logic [31:0] start;
		logic [31:0] duration;
	} entry_t;

	// per-cycle context handed to the head processor
	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] now;
		logic        hit;
		logic        found;
		logic [47:0] mac;
		logic [31:0] offer;
		logic [31:0] lease;
	} ctx_t;

	typedef struct packed {
		logic expired;
		logic grant;
	} proc_res_t;

endpackage

// File: rtl/lpu_req_if.sv
// input item channel of the lease pool
`timescale 1ns / 1ps
interface lpu_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [31:0] now_seconds;
	logic [31:0] requested_address;
	logic [47:0] client_mac;

	modport source (output valid, action, now_seconds, requested_address, client_mac,
		input ready);
	modport sink (input valid, action, now_seconds, requested_address, client_mac,
		output ready);
endinterface

// File: rtl/lpu_rsp_if.sv
// result item channel of the lease pool
`timescale 1ns / 1ps
interface lpu_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] granted_address;
	logic [6:0]  freed_count;

	modport source (output valid, status, granted_address, freed_count, input ready);
	modport sink (input valid, status, granted_address, freed_count, output ready);
endinterface

// File: rtl/lpu_cfg_if.sv
// configuration write channel of the lease pool
`timescale 1ns / 1ps
interface lpu_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/lpu_cell.sv
// one lease entry of the rotating ring
`timescale 1ns / 1ps
module lpu_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  lpu_pkg::entry_t d,
	output lpu_pkg::entry_t q
);
	import lpu_pkg::*;

	entry_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (shift) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;
endmodule

// File: rtl/lpu_proc.sv
// expiry check and offer or bind of the entry at the head of the ring
`timescale 1ns / 1ps
module lpu_proc (
	input  lpu_pkg::entry_t   ent_in,
	input  lpu_pkg::ctx_t     ctx,
	output lpu_pkg::entry_t   ent_out,
	output lpu_pkg::proc_res_t res
);
	import lpu_pkg::*;

	logic [31:0] elapsed;
	logic        expired;
	entry_t      swept;

	always_comb begin
		elapsed = ctx.now - ent_in.start;
		expired = (ent_in.state != ENT_FREE) && (elapsed > ent_in.duration);
		swept = expired ? '0 : ent_in;
		ent_out = swept;
		res.expired = expired;
		res.grant = 1'b0;
		// first free entry after the sweep takes the offer
		if (ctx.action == ACT_DISCOVER && !ctx.found && swept.state == ENT_FREE) begin
			ent_out.start = ctx.now;
			ent_out.duration = ctx.offer;
			ent_out.state = ENT_OFFERED;
			res.grant = 1'b1;
		end else if (ctx.action == ACT_REQUEST && ctx.hit && swept.state == ENT_OFFERED) begin
			ent_out.mac = ctx.mac;
			ent_out.start = ctx.now;
			ent_out.duration = ctx.lease;
			ent_out.state = ENT_BOUND;
			res.grant = 1'b1;
		end
	end
endmodule

// File: rtl/ip_lease_pool_unit.sv
// lease pool: ring of entry cells passing one head processor, with sequencer
// an accepted item makes one full turn of the ring through the head processor in ST_SCAN;
// its result then waits in ST_HOLD until the output register is free, and only ST_IDLE takes
// the next item, which is taken while a finished result still waits in the output register
// reset: all entries free and cleared, registers at their reset values, no result held
`timescale 1ns / 1ps
module ip_lease_pool_unit (
	input logic         clk,
	input logic         arst_n,
	lpu_req_if.sink     req,
	lpu_rsp_if.source   rsp,
	lpu_cfg_if.sink     cfg
);
	import lpu_pkg::*;

	state_t state_q, state_d;

	logic [31:0] base_q, offer_q, lease_q;

	logic [1:0]       act_q;
	logic [31:0]      now_q;
	logic             in_pool_q;
	logic [IDX_W-1:0] off_idx_q;
	logic [47:0]      mac_q;

	logic [IDX_W-1:0]   idx_q;
	logic [FREED_W-1:0] freed_q, freed_d;
	logic               found_q, found_d;
	logic [31:0]        granted_q, granted_d;

	logic        out_valid_q;
	logic [1:0]  out_status_q;
	logic [31:0] out_granted_q;
	logic [6:0]  out_freed_q;

	logic        accept, shift, finish, last;
	logic [31:0] off;
	logic [1:0]  status_d;

	entry_t    ring [POOL_ENTRIES];
	entry_t    head_out;
	ctx_t      ctx;
	proc_res_t res;

	// ring: cell k takes from cell k+1, the last cell takes the processed head
	for (genvar k = 0; k < POOL_ENTRIES; k++) begin : g_cell
		if (k == POOL_ENTRIES - 1) begin : g_tail
			lpu_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(shift), .d(head_out),
				.q(ring[k]));
		end else begin : g_body
			lpu_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(shift), .d(ring[k+1]),
				.q(ring[k]));
		end
	end

	always_comb begin
		ctx.action = act_q;
		ctx.now = now_q;
		ctx.hit = in_pool_q && (off_idx_q == idx_q);
		ctx.found = found_q;
		ctx.mac = mac_q;
		ctx.offer = offer_q;
		ctx.lease = lease_q;
	end

	lpu_proc u_proc (.ent_in(ring[0]), .ctx(ctx), .ent_out(head_out), .res(res));

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
			offer_q <= OFFER_RESET;
			lease_q <= LEASE_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_BASE:  base_q <= cfg.data;
				REG_OFFER: offer_q <= cfg.data;
				REG_LEASE: lease_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// sequencer
	assign last = (idx_q == IDX_W'(POOL_ENTRIES - 1));
	assign accept = req.valid && req.ready;

	always_comb begin
		state_d = state_q;
		req.ready = 1'b0;
		shift = 1'b0;
		finish = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				shift = 1'b1;
				if (last) begin
					if (!out_valid_q || rsp.ready) begin
						finish = 1'b1;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				if (!out_valid_q || rsp.ready) begin
					finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		freed_d = freed_q;
		if (shift && res.expired && freed_q != FREED_MAX) freed_d = freed_q + 1'b1;
		found_d = found_q | (shift & res.grant);
		granted_d = (shift && res.grant) ? base_q + 32'(idx_q) : granted_q;
		case (act_q)
			ACT_DISCOVER: status_d = found_d ? RES_OK : RES_NO_FREE;
			ACT_REQUEST:  status_d = found_d ? RES_OK : RES_BAD_ADDR;
			default:      status_d = RES_SWEEP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			freed_q <= '0;
			found_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				idx_q <= '0;
				freed_q <= '0;
				found_q <= 1'b0;
			end else begin
				freed_q <= freed_d;
				found_q <= found_d;
				if (shift) idx_q <= last ? '0 : idx_q + 1'b1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item context and result payload
	assign off = req.requested_address - base_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= req.action;
			now_q <= req.now_seconds;
			in_pool_q <= (off < 32'(POOL_ENTRIES));
			off_idx_q <= off[IDX_W-1:0];
			mac_q <= req.client_mac;
			granted_q <= '0;
		end else begin
			granted_q <= granted_d;
		end
		if (finish) begin
			out_status_q <= status_d;
			out_granted_q <= granted_d;
			out_freed_q <= freed_d;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.granted_address = out_granted_q;
	assign rsp.freed_count = out_freed_q;
endmodule

// File: rtl/lpu_checker.sv
// port-level checks of the lease pool, bound to the top level
`timescale 1ns / 1ps
`include "ip_lease_pool_unit_defines.svh"
module lpu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  out_status,
	input logic [31:0] out_granted,
	input logic [6:0]  out_freed
);
	import lpu_pkg::*;

	localparam int FREED_LIMIT = (POOL_ENTRIES < 127) ? POOL_ENTRIES : 127;

	// a held result keeps its payload
	`LPU_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_granted) && $stable(out_freed))
	// errors and sweeps grant no address
	`LPU_ASSERT_NOW(a_err_zero, clk, arst_n, out_valid && out_status != RES_OK, out_granted == 32'd0)
	// never more freed than the pool holds
	`LPU_ASSERT_NOW(a_freed_max, clk, arst_n, out_valid, 32'(out_freed) <= 32'(FREED_LIMIT))
	// one item at a time: a scan follows each acceptance
	`LPU_ASSERT_NEXT(a_busy, clk, arst_n, in_valid && in_ready, !in_ready)
endmodule

bind ip_lease_pool_unit lpu_checker u_lpu_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(req.valid),
	.in_ready(req.ready),
	.out_valid(rsp.valid),
	.out_ready(rsp.ready),
	.out_status(rsp.status),
	.out_granted(rsp.granted_address),
	.out_freed(rsp.freed_count)
);
